### design/ral_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the rectangle atlas allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ral_pkg;
	localparam int FREE_DEPTH  = 64;
	localparam int FREE_AW     = $clog2(FREE_DEPTH);
	localparam int FREE_CW     = $clog2(FREE_DEPTH + 1);
	localparam int IMAGE_SLOTS = 32;
	localparam int SLOT_W      = $clog2(IMAGE_SLOTS);
	localparam int DIM_W       = 13;
	localparam int MAX_DIM     = 4096;
	localparam int SID_W       = 64;
	localparam int OFF_W       = 28;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LARGE = 3'd1,
		ST_NOFIT = 3'd2,
		ST_FULL  = 3'd3,
		ST_MISS  = 3'd4
	} status_t;

	localparam logic [1:0] FN_ADD    = 2'd0;
	localparam logic [1:0] FN_LOOKUP = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BPP    = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic               we;
		logic [FREE_AW-1:0] waddr;
		rect_t              wdata;
		logic [FREE_AW-1:0] raddr;
	} free_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [SID_W-1:0]  wsid;
		rect_t             wrect;
		logic [SLOT_W-1:0] raddr;
	} img_req_t;
endpackage
`default_nettype wire

### design/ral_free_list.sv
`timescale 1ns / 1ps
// Free rectangle list memory: one write and one registered read per cycle.
// Depends on ral_pkg.
`default_nettype none
module ral_free_list (
	input  wire logic              clk,
	input  ral_pkg::free_req_t     req,
	output ral_pkg::rect_t         rdata
);
	ral_pkg::rect_t mem [ral_pkg::FREE_DEPTH];

	// write and read the list
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule
`default_nettype wire

### design/ral_image_store.sv
`timescale 1ns / 1ps
// Image table memory: sid and rectangle per slot, registered read.
// Depends on ral_pkg.
`default_nettype none
module ral_image_store (
	input  wire logic                      clk,
	input  ral_pkg::img_req_t              req,
	output logic [ral_pkg::SID_W-1:0]      rsid,
	output ral_pkg::rect_t                 rrect
);
	logic [ral_pkg::SID_W-1:0] sid_mem [ral_pkg::IMAGE_SLOTS];
	ral_pkg::rect_t rect_mem [ral_pkg::IMAGE_SLOTS];

	// write and read the table
	always_ff @(posedge clk) begin
		if (req.we) begin
			sid_mem[req.waddr]  <= req.wsid;
			rect_mem[req.waddr] <= req.wrect;
		end
		rsid  <= sid_mem[req.raddr];
		rrect <= rect_mem[req.raddr];
	end
endmodule
`default_nettype wire

### design/ral_offset.sv
`timescale 1ns / 1ps
// Two-stage byte offset pipeline: (y*atlas_width + x)*bytes_per_pixel.
// Depends on ral_pkg.
`default_nettype none
module ral_offset (
	input  wire logic                        clk,
	input  wire logic [ral_pkg::DIM_W-1:0]   x,
	input  wire logic [ral_pkg::DIM_W-1:0]   y,
	input  wire logic [ral_pkg::DIM_W-1:0]   aw,
	input  wire logic [4:0]                  bpp,
	output logic [ral_pkg::OFF_W-1:0]        off
);
	logic [2*ral_pkg::DIM_W-1:0] prod_s1;
	logic [ral_pkg::DIM_W-1:0]   x_s1;
	logic [2*ral_pkg::DIM_W:0]   sum;
	logic [2*ral_pkg::DIM_W+5:0] full;

	assign sum  = {1'b0, prod_s1} + {{(ral_pkg::DIM_W+1){1'b0}}, x_s1};
	assign full = sum * bpp;

	// row product, then add column and scale
	always_ff @(posedge clk) begin
		prod_s1 <= y * aw;
		x_s1    <= x;
		off     <= full[ral_pkg::OFF_W-1:0];
	end
endmodule
`default_nettype wire

### design/rect_atlas_allocator.sv
`timescale 1ns / 1ps
// Top level of the rectangle atlas allocator: control sequencer, image valid bits.
// Depends on ral_pkg, ral_free_list, ral_image_store, ral_offset.
//
// Use: raise start with func and its operands while busy is low; the request
// is taken at that edge and busy rises. Exactly one result beat follows,
// shown for one cycle with done high; the receiver cannot stall it.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is high only while idle with start low, so a request
// offered together with a write is taken first. Writing the atlas width or
// height re-initialises the lists. An add scans the free entries in order
// for the first that fits, moves the later entries up to take it out,
// appends the right and lower pieces, then runs the offset multiply and
// shows the result; with no fit the scan ends in the result. A lookup scans
// the slots in order and runs the offset multiply on a hit. A remove reads
// the slot, appends its rectangle to the free list and runs the offset
// multiply. Too large, store full, bad slot and unused func go straight to
// the result. The state memories take one write and one registered read per
// cycle; the block handles one request at a time and returns to idle after
// done. Reset clears the registers to 1024 x 1024 at 4 bytes per pixel and
// runs an init that writes the whole-atlas free rectangle.
`default_nettype none
module rect_atlas_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        func,
	input  wire logic [ral_pkg::DIM_W-1:0]         req_width,
	input  wire logic [ral_pkg::DIM_W-1:0]         req_height,
	input  wire logic [ral_pkg::SID_W-1:0]         image_id,
	input  wire logic [ral_pkg::SLOT_W-1:0]        slot_in,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [ral_pkg::DIM_W-1:0]         cfg_data,
	output logic                                   done,
	output logic [2:0]                             status,
	output logic [ral_pkg::SLOT_W-1:0]             slot_out,
	output logic [11:0]                            pos_x,
	output logic [11:0]                            pos_y,
	output logic [ral_pkg::DIM_W-1:0]              img_width,
	output logic [ral_pkg::DIM_W-1:0]              img_height,
	output logic [ral_pkg::OFF_W-1:0]              byte_offset
);
	typedef enum logic [14:0] {
		S_INIT = 15'b000000000000001,
		S_IDLE = 15'b000000000000010,
		S_FRD  = 15'b000000000000100,
		S_FCHK = 15'b000000000001000,
		S_MRD  = 15'b000000000010000,
		S_MWR  = 15'b000000000100000,
		S_WR1  = 15'b000000001000000,
		S_WR2  = 15'b000000010000000,
		S_LRD  = 15'b000000100000000,
		S_LCHK = 15'b000001000000000,
		S_RRD  = 15'b000010000000000,
		S_RWR  = 15'b000100000000000,
		S_MUL1 = 15'b001000000000000,
		S_MUL2 = 15'b010000000000000,
		S_OUT  = 15'b100000000000000
	} state_t;

	localparam logic [ral_pkg::FREE_CW-1:0] FREE_FULL = ral_pkg::FREE_CW'(ral_pkg::FREE_DEPTH);
	localparam logic [ral_pkg::SLOT_W-1:0]  LAST_SLOT = ral_pkg::SLOT_W'(ral_pkg::IMAGE_SLOTS - 1);
	localparam logic [ral_pkg::DIM_W-1:0]   MAX_D     = ral_pkg::DIM_W'(ral_pkg::MAX_DIM);

	state_t                          state_q;
	logic [ral_pkg::DIM_W-1:0]       aw_q, ah_q;
	logic [4:0]                      bpp_q;
	logic [ral_pkg::FREE_CW-1:0]     cnt_q;
	logic [ral_pkg::IMAGE_SLOTS-1:0] valid_q;
	logic [1:0]                      func_q;
	logic [ral_pkg::DIM_W-1:0]       rw_q, rh_q;
	logic [ral_pkg::SID_W-1:0]       sid_q;
	logic [ral_pkg::SLOT_W-1:0]      slot_q;
	logic [ral_pkg::FREE_AW-1:0]     idx_q;
	ral_pkg::rect_t                  g_q;
	ral_pkg::status_t                res_st_q;
	logic [ral_pkg::SLOT_W-1:0]      res_slot_q;
	ral_pkg::rect_t                  res_rect_q;

	ral_pkg::free_req_t              free_req;
	ral_pkg::rect_t                  free_rd;
	ral_pkg::img_req_t               img_req;
	logic [ral_pkg::SID_W-1:0]       img_sid;
	ral_pkg::rect_t                  img_rect;
	logic [ral_pkg::OFF_W-1:0]       off;
	logic                            have_slot;
	logic [ral_pkg::SLOT_W-1:0]      free_slot;
	logic [ral_pkg::DIM_W-1:0]       sat;
	logic [ral_pkg::FREE_CW-1:0]     idx_ext;

	ral_free_list u_free (.clk(clk), .req(free_req), .rdata(free_rd));
	ral_image_store u_img (.clk(clk), .req(img_req), .rsid(img_sid), .rrect(img_rect));
	ral_offset u_off (
		.clk(clk), .x(res_rect_q.x), .y(res_rect_q.y), .aw(aw_q), .bpp(bpp_q), .off(off)
	);

	// lowest free image slot
	always_comb begin
		have_slot = 1'b0;
		free_slot = '0;
		for (int i = ral_pkg::IMAGE_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				have_slot = 1'b1;
				free_slot = ral_pkg::SLOT_W'(i);
			end
		end
	end

	assign sat     = (cfg_data > MAX_D) ? MAX_D : cfg_data;
	assign idx_ext = {1'b0, idx_q};
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	// memory ports driven from the state
	always_comb begin
		free_req       = '0;
		img_req        = '0;
		free_req.raddr = idx_q;
		img_req.raddr  = idx_q[ral_pkg::SLOT_W-1:0];
		unique case (state_q)
			S_INIT: begin
				free_req.we    = 1'b1;
				free_req.waddr = '0;
				free_req.wdata = '{x: '0, y: '0, w: aw_q, h: ah_q};
			end
			S_MRD: free_req.raddr = idx_q + 1'b1;
			S_MWR: begin
				free_req.we    = 1'b1;
				free_req.waddr = idx_q;
				free_req.wdata = free_rd;
			end
			S_WR1: begin
				free_req.we    = 1'b1;
				free_req.waddr = ral_pkg::FREE_AW'(cnt_q - 1'b1);
				free_req.wdata = '{x: g_q.x + rw_q, y: g_q.y, w: g_q.w - rw_q, h: rh_q};
			end
			S_WR2: begin
				free_req.we    = 1'b1;
				free_req.waddr = cnt_q[ral_pkg::FREE_AW-1:0];
				free_req.wdata = '{x: g_q.x, y: g_q.y + rh_q, w: g_q.w, h: g_q.h - rh_q};
				img_req.we     = 1'b1;
				img_req.waddr  = slot_q;
				img_req.wsid   = sid_q;
				img_req.wrect  = '{x: g_q.x, y: g_q.y, w: rw_q, h: rh_q};
			end
			S_RRD: img_req.raddr = slot_q;
			S_RWR: begin
				free_req.we    = 1'b1;
				free_req.waddr = cnt_q[ral_pkg::FREE_AW-1:0];
				free_req.wdata = img_rect;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			aw_q       <= ral_pkg::DIM_W'(1024);
			ah_q       <= ral_pkg::DIM_W'(1024);
			bpp_q      <= 5'd4;
			cnt_q      <= '0;
			valid_q    <= '0;
			res_st_q   <= ral_pkg::ST_OK;
			func_q     <= '0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					cnt_q   <= ral_pkg::FREE_CW'(1);
					valid_q <= '0;
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					res_slot_q <= '0;
					res_rect_q <= '0;
					idx_q      <= '0;
					if (cfg_valid && !start) begin
						if (cfg_index == ral_pkg::CFG_WIDTH) begin
							aw_q    <= sat;
							state_q <= S_INIT;
						end else if (cfg_index == ral_pkg::CFG_HEIGHT) begin
							ah_q    <= sat;
							state_q <= S_INIT;
						end else if (cfg_index == ral_pkg::CFG_BPP) begin
							bpp_q <= cfg_data[4:0];
						end
					end else if (start) begin
						func_q <= func;
						rw_q   <= req_width;
						rh_q   <= req_height;
						sid_q  <= image_id;
						slot_q <= (func == ral_pkg::FN_ADD) ? free_slot : slot_in;
						if (func == ral_pkg::FN_ADD) begin
							if (req_width > aw_q || req_height > ah_q) begin
								res_st_q <= ral_pkg::ST_LARGE;
								state_q  <= S_OUT;
							end else if (!have_slot || cnt_q >= FREE_FULL) begin
								res_st_q <= ral_pkg::ST_FULL;
								state_q  <= S_OUT;
							end else if (cnt_q == '0) begin
								res_st_q <= ral_pkg::ST_NOFIT;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_FRD;
							end
						end else if (func == ral_pkg::FN_LOOKUP) begin
							state_q <= S_LRD;
						end else if (func == ral_pkg::FN_REMOVE) begin
							if (!valid_q[slot_in]) begin
								res_st_q <= ral_pkg::ST_MISS;
								state_q  <= S_OUT;
							end else if (cnt_q >= FREE_FULL) begin
								res_st_q <= ral_pkg::ST_FULL;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_RRD;
							end
						end else begin
							res_st_q <= ral_pkg::ST_MISS;
							state_q  <= S_OUT;
						end
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (free_rd.w >= rw_q && free_rd.h >= rh_q) begin
						g_q     <= free_rd;
						state_q <= (idx_ext + 1'b1 < cnt_q) ? S_MRD : S_WR1;
					end else if (idx_ext + 1'b1 < cnt_q) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FRD;
					end else begin
						res_st_q <= ral_pkg::ST_NOFIT;
						state_q  <= S_OUT;
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_ext + 2'd2 < cnt_q) ? S_MRD : S_WR1;
				end
				S_WR1: state_q <= S_WR2;
				S_WR2: begin
					cnt_q           <= cnt_q + 1'b1;
					valid_q[slot_q] <= 1'b1;
					res_st_q        <= ral_pkg::ST_OK;
					res_slot_q      <= slot_q;
					res_rect_q      <= '{x: g_q.x, y: g_q.y, w: rw_q, h: rh_q};
					state_q         <= S_MUL1;
				end
				S_LRD: state_q <= S_LCHK;
				S_LCHK: begin
					if (valid_q[idx_q[ral_pkg::SLOT_W-1:0]] && img_sid == sid_q) begin
						res_st_q   <= ral_pkg::ST_OK;
						res_slot_q <= idx_q[ral_pkg::SLOT_W-1:0];
						res_rect_q <= img_rect;
						state_q    <= S_MUL1;
					end else if (idx_q[ral_pkg::SLOT_W-1:0] == LAST_SLOT) begin
						res_st_q <= ral_pkg::ST_MISS;
						state_q  <= S_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					cnt_q           <= cnt_q + 1'b1;
					valid_q[slot_q] <= 1'b0;
					res_st_q        <= ral_pkg::ST_OK;
					res_slot_q      <= slot_q;
					res_rect_q      <= img_rect;
					state_q         <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_OUT;
				S_OUT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat
	assign done        = (state_q == S_OUT);
	assign status      = res_st_q;
	assign slot_out    = res_slot_q;
	assign pos_x       = res_rect_q.x[11:0];
	assign pos_y       = res_rect_q.y[11:0];
	assign img_width   = res_rect_q.w;
	assign img_height  = res_rect_q.h;
	assign byte_offset = (res_st_q == ral_pkg::ST_OK) ? off : '0;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FREE_FULL) else $error("free count beyond list depth");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res_st_q != ral_pkg::ST_OK |-> slot_out == '0 && byte_offset == '0)
		else $error("rejected result carries data");
	a_add_marks: assert property (@(posedge clk) disable iff (!arst_n)
		done && res_st_q == ral_pkg::ST_OK && func_q == ral_pkg::FN_ADD |-> valid_q[slot_out])
		else $error("placed slot not marked valid");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request left block idle");
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the rectangle atlas allocator: directed and random requests
// checked against a behavioural first-fit guillotine allocator held in the bench.
// Depends on ral_pkg and rect_atlas_allocator.
`default_nettype none
module testbench;
	typedef struct {
		logic [1:0]                 fn;
		logic [ral_pkg::DIM_W-1:0]  w;
		logic [ral_pkg::DIM_W-1:0]  h;
		logic [ral_pkg::SID_W-1:0]  sid;
		logic [ral_pkg::SLOT_W-1:0] slot;
	} request_t;

	typedef struct {
		ral_pkg::status_t           st;
		logic [ral_pkg::SLOT_W-1:0] slot;
		logic [11:0]                x;
		logic [11:0]                y;
		logic [ral_pkg::DIM_W-1:0]  w;
		logic [ral_pkg::DIM_W-1:0]  h;
		logic [ral_pkg::OFF_W-1:0]  off;
	} placement_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES         = 9;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] func = ral_pkg::FN_ADD;
	logic [ral_pkg::DIM_W-1:0] req_width = '0;
	logic [ral_pkg::DIM_W-1:0] req_height = '0;
	logic [ral_pkg::SID_W-1:0] image_id = '0;
	logic [ral_pkg::SLOT_W-1:0] slot_in = '0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = ral_pkg::CFG_WIDTH;
	logic [ral_pkg::DIM_W-1:0] cfg_data = '0;
	logic busy, cfg_ready, done;
	logic [2:0] status;
	logic [ral_pkg::SLOT_W-1:0] slot_out;
	logic [11:0] pos_x, pos_y;
	logic [ral_pkg::DIM_W-1:0] img_width, img_height;
	logic [ral_pkg::OFF_W-1:0] byte_offset;

	rect_atlas_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.req_width(req_width), .req_height(req_height), .image_id(image_id),
		.slot_in(slot_in), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
		.slot_out(slot_out), .pos_x(pos_x), .pos_y(pos_y), .img_width(img_width),
		.img_height(img_height), .byte_offset(byte_offset)
	);

	always #10 clk = ~clk;

	// Allocator state as the bench sees it
	int unsigned atlas_w = 1024, atlas_h = 1024, pix_bytes = 4;
	ral_pkg::rect_t free_list[ral_pkg::FREE_DEPTH];
	int unsigned free_n;
	logic slot_used[ral_pkg::IMAGE_SLOTS];
	logic [ral_pkg::SID_W-1:0] slot_sid[ral_pkg::IMAGE_SLOTS];
	ral_pkg::rect_t slot_rect[ral_pkg::IMAGE_SLOTS];

	request_t pending_q[$];
	placement_t placement_q[$];
	request_t cur;
	int gap_left = 0;
	logic take, next_start;
	int errors = 0, requests_taken = 0, results_seen = 0;
	int status_seen[5];
	logic [ral_pkg::SID_W-1:0] sid_pool[8];
	int unsigned cfg_w[PHASES] = '{64, 4096, 8191, 1, 200, 32, 4096, 100, 1024};
	int unsigned cfg_h[PHASES] = '{64, 4096, 1, 4096, 8191, 32, 16, 100, 1024};
	int unsigned cfg_b[PHASES] = '{16, 1, 3, 7, 16, 2, 5, 1, 4};
	int unsigned add_pct[PHASES] = '{60, 55, 50, 50, 85, 90, 60, 45, 55};

	function automatic int unsigned clamp_dim(int unsigned v);
		v = v & 32'h1FFF;
		return (v > ral_pkg::MAX_DIM) ? ral_pkg::MAX_DIM : v;
	endfunction

	function automatic void clear_allocator();
		free_list[0] = '{x: '0, y: '0, w: atlas_w[ral_pkg::DIM_W-1:0],
			h: atlas_h[ral_pkg::DIM_W-1:0]};
		free_n = 1;
		foreach (slot_used[i]) slot_used[i] = 1'b0;
	endfunction

	// Append one request to the pending queue
	function automatic void enqueue(request_t rq);
		pending_q.insert(pending_q.size(), rq);
	endfunction

	function automatic placement_t make_placement(ral_pkg::status_t st, int unsigned slot,
			ral_pkg::rect_t r);
		placement_t p;
		longint unsigned off;
		p = '{st: st, slot: '0, x: '0, y: '0, w: '0, h: '0, off: '0};
		if (st != ral_pkg::ST_OK) return p;
		off = (longint'(r.y) * atlas_w + r.x) * pix_bytes;
		p.slot = slot[ral_pkg::SLOT_W-1:0];
		p.x = r.x[11:0];
		p.y = r.y[11:0];
		p.w = r.w;
		p.h = r.h;
		p.off = off[ral_pkg::OFF_W-1:0];
		return p;
	endfunction

	// Apply one request to the bench copy and return the placement it reports
	function automatic placement_t allocate(request_t rq);
		ral_pkg::rect_t g, img, none;
		int slot;
		none = '0;
		case (rq.fn)
			ral_pkg::FN_ADD: begin
				if (rq.w > atlas_w || rq.h > atlas_h)
					return make_placement(ral_pkg::ST_LARGE, 0, none);
				slot = -1;
				for (int i = 0; i < ral_pkg::IMAGE_SLOTS; i++)
					if (!slot_used[i] && slot < 0) slot = i;
				if (slot < 0 || free_n + 1 > ral_pkg::FREE_DEPTH)
					return make_placement(ral_pkg::ST_FULL, 0, none);
				for (int i = 0; i < free_n; i++) begin
					g = free_list[i];
					if (g.w < rq.w || g.h < rq.h) continue;
					// close up the list, then append right and lower pieces
					for (int j = i; j < free_n - 1; j++) free_list[j] = free_list[j+1];
					free_list[free_n-1] = '{x: g.x + rq.w, y: g.y, w: g.w - rq.w, h: rq.h};
					free_list[free_n] = '{x: g.x, y: g.y + rq.h, w: g.w, h: g.h - rq.h};
					free_n++;
					img = '{x: g.x, y: g.y, w: rq.w, h: rq.h};
					slot_used[slot] = 1'b1;
					slot_sid[slot] = rq.sid;
					slot_rect[slot] = img;
					return make_placement(ral_pkg::ST_OK, slot, img);
				end
				return make_placement(ral_pkg::ST_NOFIT, 0, none);
			end
			ral_pkg::FN_LOOKUP: begin
				for (int i = 0; i < ral_pkg::IMAGE_SLOTS; i++)
					if (slot_used[i] && slot_sid[i] == rq.sid)
						return make_placement(ral_pkg::ST_OK, i, slot_rect[i]);
				return make_placement(ral_pkg::ST_MISS, 0, none);
			end
			ral_pkg::FN_REMOVE: begin
				if (!slot_used[rq.slot]) return make_placement(ral_pkg::ST_MISS, 0, none);
				if (free_n >= ral_pkg::FREE_DEPTH)
					return make_placement(ral_pkg::ST_FULL, 0, none);
				free_list[free_n] = slot_rect[rq.slot];
				free_n++;
				slot_used[rq.slot] = 1'b0;
				return make_placement(ral_pkg::ST_OK, rq.slot, slot_rect[rq.slot]);
			end
			default: return make_placement(ral_pkg::ST_MISS, 0, none);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic request_t random_request(int unsigned pct);
		request_t rq;
		int r;
		r = $urandom_range(0, 99);
		rq.fn = (r < pct) ? ral_pkg::FN_ADD :
			(r < pct + (100 - pct) * 2 / 5) ? ral_pkg::FN_LOOKUP :
			(r < 96) ? ral_pkg::FN_REMOVE : 2'd3;
		rq.sid = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
			sid_pool[$urandom_range(0, 7)];
		rq.slot = ral_pkg::SLOT_W'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 5) rq.w = '0;
		else if (r < 10) rq.w = ral_pkg::DIM_W'($urandom);
		else if (r < 14) rq.w = ral_pkg::DIM_W'(atlas_w + 1);
		else rq.w = ral_pkg::DIM_W'($urandom_range(1, (atlas_w / 4 > 1) ? atlas_w / 4 : 1));
		r = $urandom_range(0, 99);
		if (r < 5) rq.h = '0;
		else if (r < 10) rq.h = ral_pkg::DIM_W'($urandom);
		else if (r < 14) rq.h = ral_pkg::DIM_W'(atlas_h + 1);
		else rq.h = ral_pkg::DIM_W'($urandom_range(1, (atlas_h / 4 > 1) ? atlas_h / 4 : 1));
		return rq;
	endfunction

	function automatic request_t req(logic [1:0] fn, int unsigned w, int unsigned h,
			logic [ral_pkg::SID_W-1:0] sid, int unsigned slot);
		request_t rq;
		rq = '{fn: fn, w: w[ral_pkg::DIM_W-1:0], h: h[ral_pkg::DIM_W-1:0], sid: sid,
			slot: slot[ral_pkg::SLOT_W-1:0]};
		return rq;
	endfunction

	// Write one register; hold valid until ready is seen at an edge
	task automatic write_register(logic [1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[ral_pkg::DIM_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ral_pkg::CFG_WIDTH: begin atlas_w = clamp_dim(value); clear_allocator(); end
			ral_pkg::CFG_HEIGHT: begin atlas_h = clamp_dim(value); clear_allocator(); end
			default: pix_bytes = value & 32'h1F;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || start || placement_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic report(string field, longint unsigned got, longint unsigned want);
		$display("[%0t] %s: got %0h, expected %0h", $time, field, got, want);
		errors++;
	endtask

	// Driver: present the next queued request after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			take = start && !busy;
			if (take) begin
				placement_q.insert(placement_q.size(), allocate(cur));
				requests_taken++;
			end
			next_start = start && !take;
			if (!start || take) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() != 0) begin
					cur = pending_q.pop_front();
					func <= cur.fn;
					req_width <= cur.w;
					req_height <= cur.h;
					image_id <= cur.sid;
					slot_in <= cur.slot;
					next_start = 1'b1;
					gap_left = pick_gap();
				end
			end
			start <= next_start;
		end
	end

	// Monitor: check each result beat against the oldest expectation
	always @(posedge clk) begin
		placement_t want;
		if (arst_n && done) begin
			results_seen++;
			if (placement_q.size() == 0) begin
				report("unexpected result, status", status, 0);
			end else begin
				want = placement_q.pop_front();
				if (want.st <= ral_pkg::ST_MISS) status_seen[want.st]++;
				if (status !== want.st) report("status", status, want.st);
				if (slot_out !== want.slot) report("slot_out", slot_out, want.slot);
				if (pos_x !== want.x) report("pos_x", pos_x, want.x);
				if (pos_y !== want.y) report("pos_y", pos_y, want.y);
				if (img_width !== want.w) report("img_width", img_width, want.w);
				if (img_height !== want.h) report("img_height", img_height, want.h);
				if (byte_offset !== want.off) report("byte_offset", byte_offset, want.off);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	int quiet = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clear_allocator();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed beats on the reset-state 1024 x 1024 atlas
		enqueue(req(ral_pkg::FN_ADD, 0, 0, '1, 0));
		enqueue(req(ral_pkg::FN_ADD, 1024, 1024, 64'h0123_4567_89AB_CDEF, 0));
		enqueue(req(ral_pkg::FN_ADD, 1, 1, 64'h5, 0));
		enqueue(req(ral_pkg::FN_ADD, 1025, 1, 64'h6, 0));
		enqueue(req(ral_pkg::FN_ADD, 8191, 8191, 64'h7, 0));
		enqueue(req(ral_pkg::FN_ADD, 1, 1025, 64'h7, 0));
		enqueue(req(ral_pkg::FN_ADD, 0, 1024, 64'h8, 0));
		enqueue(req(ral_pkg::FN_LOOKUP, 0, 0, '1, 0));
		enqueue(req(ral_pkg::FN_LOOKUP, 0, 0, '0, 0));
		enqueue(req(ral_pkg::FN_LOOKUP, 0, 0, 64'h0123_4567_89AB_CDEF, 0));
		enqueue(req(ral_pkg::FN_REMOVE, 0, 0, 0, 1));
		enqueue(req(ral_pkg::FN_REMOVE, 0, 0, 0, 1));
		enqueue(req(ral_pkg::FN_REMOVE, 0, 0, 0, 31));
		enqueue(req(2'd3, 8191, 8191, '1, 31));
		enqueue(req(ral_pkg::FN_ADD, 512, 512, '1, 0));
		enqueue(req(ral_pkg::FN_LOOKUP, 0, 0, '1, 0));
		enqueue(req(ral_pkg::FN_ADD, 0, 0, 64'h8, 0));
		enqueue(req(ral_pkg::FN_LOOKUP, 0, 0, 64'h8, 0));
		drain();

		// Random phases, each on a fresh atlas setting
		for (int p = 0; p < PHASES; p++) begin
			write_register(ral_pkg::CFG_WIDTH, cfg_w[p]);
			write_register(ral_pkg::CFG_HEIGHT, cfg_h[p]);
			write_register(ral_pkg::CFG_BPP, cfg_b[p]);
			foreach (sid_pool[i]) sid_pool[i] = {$urandom, $urandom};
			for (int n = 0; n < 55; n++) begin
				enqueue(random_request(add_pct[p]));
				// stretch without gaps now and then
				if (n == 20) gap_left = 0;
			end
			drain();
		end

		$display("%0d requests over %0d atlas settings; ok %0d, too large %0d, no fit %0d,",
			requests_taken, PHASES + 1, status_seen[ral_pkg::ST_OK],
			status_seen[ral_pkg::ST_LARGE], status_seen[ral_pkg::ST_NOFIT]);
		$display("store full %0d, not found %0d; %0d field mismatches",
			status_seen[ral_pkg::ST_FULL], status_seen[ral_pkg::ST_MISS], errors);
		if (errors == 0 && placement_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire
